// ===== rtl/phf_pkg.sv =====
// Shared types and constants for the packet header filter.
// No dependencies; imported by every module of the block.
package phf_pkg;

  localparam int unsigned POS_W = 7;  // byte position / count width, saturates at 127
  localparam logic [POS_W-1:0] POS_MAX = 7'd127;

  // Layer 3 start for each link kind
  localparam int unsigned NUM_ROWS = 3;
  localparam int unsigned ROW_RAW = 0;
  localparam int unsigned ROW_ETH = 1;
  localparam int unsigned ROW_COOKED = 2;
  localparam logic [POS_W-1:0] L3_OFF [NUM_ROWS] = '{7'd0, 7'd14, 7'd16};

  // Minimum captured lengths
  localparam logic [POS_W-1:0] MIN_RAW_LEN = 7'd20;
  localparam logic [POS_W-1:0] MIN_COOKED_LEN = 7'd16;
  localparam logic [POS_W-1:0] MIN_ETH_LEN = 7'd14;
  localparam logic [POS_W-1:0] MIN_IPV4_LEN = 7'd20;
  localparam logic [POS_W-1:0] MIN_IPV6_LEN = 7'd40;
  localparam logic [POS_W-1:0] MIN_IPV6_L4_LEN = 7'd44;
  localparam logic [POS_W-1:0] PORT_BYTES = 7'd4;

  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;
  localparam logic [15:0] ET_ARP = 16'h0806;
  localparam logic [15:0] ET_NONE = 16'h0000;

  localparam logic [3:0] IP_VER4 = 4'h4;
  localparam logic [3:0] IP_VER6 = 4'h6;
  localparam logic [15:0] SLL_PKTTYPE_MAX = 16'd4;
  localparam logic [15:0] ARPHRD_NETROM = 16'd0;
  localparam logic [15:0] ARPHRD_ETHER = 16'd1;
  localparam logic [15:0] ARPHRD_LOOPBACK = 16'd772;

  localparam logic [7:0] PROTO_ANY = 8'd0;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [15:0] PORT_ANY = 16'd0;
  localparam logic [15:0] PORT_HTTP = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_DNS = 16'd53;

  // filter_mode codes; the unused code behaves as MODE_ALL
  localparam logic [2:0] MODE_ALL = 3'd0;
  localparam logic [2:0] MODE_ARP = 3'd1;
  localparam logic [2:0] MODE_HTTP = 3'd2;
  localparam logic [2:0] MODE_HTTPS = 3'd3;
  localparam logic [2:0] MODE_DNS = 3'd4;
  localparam logic [2:0] MODE_TCP = 3'd5;
  localparam logic [2:0] MODE_UDP = 3'd6;

  // link_kind codes
  localparam logic [1:0] KIND_RAW = 2'd0;
  localparam logic [1:0] KIND_COOKED = 2'd1;
  localparam logic [1:0] KIND_ETH = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_FILTER_MODE = 3'd0;
  localparam logic [2:0] CFG_MATCH_PROTO = 3'd1;
  localparam logic [2:0] CFG_SRC_EN = 3'd2;
  localparam logic [2:0] CFG_SRC_ADDR = 3'd3;
  localparam logic [2:0] CFG_DST_EN = 3'd4;
  localparam logic [2:0] CFG_DST_ADDR = 3'd5;
  localparam logic [2:0] CFG_SRC_PORT = 3'd6;
  localparam logic [2:0] CFG_DST_PORT = 3'd7;

  typedef struct packed {
    logic [2:0]  filter_mode;
    logic [7:0]  match_protocol;
    logic        source_address_enable;
    logic [31:0] source_address;
    logic        dest_address_enable;
    logic [31:0] dest_address;
    logic [15:0] match_source_port;
    logic [15:0] match_dest_port;
  } cfg_t;

  // one frame byte with its position in the frame
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [POS_W-1:0] pos;
  } item_t;

  // fields picked up relative to one candidate layer 3 start
  typedef struct packed {
    logic [3:0]  ihl;
    logic [7:0]  nh;      // IPv6 next header
    logic [7:0]  proto;   // IPv4 protocol
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports4;  // src/dst port at 4*IHL
    logic [31:0] ports6;  // src/dst port after the fixed IPv6 header
  } l3_fields_t;

  typedef struct packed {
    logic [POS_W-1:0] len;
    logic [15:0]      word0;  // bytes 0-1
    logic [15:0]      word2;  // bytes 2-3
    logic [15:0]      et12;
    logic [15:0]      et14;
  } link_fields_t;

  typedef struct packed {
    logic        accept;
    logic [1:0]  link_kind;
    logic [15:0] ether_type;
  } verdict_t;

endpackage

// ===== rtl/packet_header_filter_top.sv =====
// Packet header filter: one frame byte per cycle, one verdict per frame.
// The last byte passes the input, capture and output registers before out_tvalid rises.
// Throughput: one byte per cycle; input stalls only while a verdict waits behind
// an unaccepted result in the output register.
// Reset (rst_n low, synchronous): pipeline empty, byte count 0, all config regs 0.
module packet_header_filter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] accept, [16:1] frame_ether_type, [23:17] zero
  output logic [1:0]  out_tuser,  // [1:0] link_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import phf_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  logic              a_valid_r, a_valid_nxt;
  item_t             a_item_r, a_item_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  verdict_t          out_r, out_nxt;

  logic              in_acc, out_free, done, take, hold, load;
  link_fields_t      link;
  l3_fields_t        rows [NUM_ROWS];
  verdict_t          verdict;

  assign in_acc = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign take = done && out_free;
  assign hold = done && !out_free;  // a verdict is parked in the capture stage
  assign load = a_valid_r && !hold;
  assign in_tready = !a_valid_r || !hold;
  assign cfg_ready = 1'b1;

  phf_capture u_capture (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .take  (take),
    .item  (a_item_r),
    .done  (done),
    .link  (link),
    .rows  (rows)
  );

  phf_verdict u_verdict (
    .cfg     (cfg_r),
    .link    (link),
    .rows    (rows),
    .verdict (verdict)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_MODE: cfg_nxt.filter_mode = cfg_data[2:0];
        CFG_MATCH_PROTO: cfg_nxt.match_protocol = cfg_data[7:0];
        CFG_SRC_EN:      cfg_nxt.source_address_enable = cfg_data[0];
        CFG_SRC_ADDR:    cfg_nxt.source_address = cfg_data;
        CFG_DST_EN:      cfg_nxt.dest_address_enable = cfg_data[0];
        CFG_DST_ADDR:    cfg_nxt.dest_address = cfg_data;
        CFG_SRC_PORT:    cfg_nxt.match_source_port = cfg_data[15:0];
        CFG_DST_PORT:    cfg_nxt.match_dest_port = cfg_data[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    a_valid_nxt = load ? 1'b0 : a_valid_r;
    a_item_nxt = a_item_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
      a_item_nxt.data = in_tdata;
      a_item_nxt.last = in_tlast;
      a_item_nxt.pos = cnt_r;
      if (in_tlast)
        cnt_nxt = '0;
      else if (cnt_r != POS_MAX)
        cnt_nxt = cnt_r + 7'd1;
    end

    out_valid_nxt = take ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_nxt = take ? verdict : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      a_valid_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      a_valid_r <= a_valid_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r <= a_item_nxt;
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'd0, out_r.ether_type, out_r.accept};
  assign out_tuser = out_r.link_kind;

endmodule

// ===== rtl/phf_capture.sv =====
// Header field capture: picks the bytes the verdict needs out of the byte stream.
// Depends on phf_pkg.
module phf_capture (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic                        take,
  input  phf_pkg::item_t              item,
  output logic                        done,
  output phf_pkg::link_fields_t       link,
  output phf_pkg::l3_fields_t         rows [phf_pkg::NUM_ROWS]
);
  import phf_pkg::*;

  link_fields_t link_r, link_nxt;
  l3_fields_t   rows_r [NUM_ROWS];
  l3_fields_t   rows_nxt [NUM_ROWS];
  logic         done_r, done_nxt;

  always_comb begin
    logic [POS_W-1:0] rel;
    logic [3:0]       ihl_c;
    logic [POS_W-1:0] l4;

    rel = '0;
    ihl_c = '0;
    l4 = '0;
    link_nxt = link_r;
    rows_nxt = rows_r;
    done_nxt = take ? 1'b0 : done_r;

    if (load) begin
      done_nxt = item.last;
      link_nxt.len = (item.pos == POS_MAX) ? POS_MAX : item.pos + 7'd1;
      if (item.pos <= 7'd1)
        link_nxt.word0 = {link_r.word0[7:0], item.data};
      if (item.pos == 7'd2 || item.pos == 7'd3)
        link_nxt.word2 = {link_r.word2[7:0], item.data};
      if (item.pos == 7'd12 || item.pos == 7'd13)
        link_nxt.et12 = {link_r.et12[7:0], item.data};
      if (item.pos == 7'd14 || item.pos == 7'd15)
        link_nxt.et14 = {link_r.et14[7:0], item.data};

      for (int j = 0; j < NUM_ROWS; j++) begin
        if (item.pos >= L3_OFF[j]) begin
          rel = item.pos - L3_OFF[j];
          // with an IHL of 0 the port window starts on the IHL byte itself
          ihl_c = (rel == 7'd0) ? item.data[3:0] : rows_r[j].ihl;
          l4 = {1'b0, ihl_c, 2'b00};
          if (rel == 7'd0) rows_nxt[j].ihl = item.data[3:0];
          if (rel == 7'd6) rows_nxt[j].nh = item.data;
          if (rel == 7'd9) rows_nxt[j].proto = item.data;
          if (rel >= 7'd12 && rel <= 7'd15)
            rows_nxt[j].src = {rows_r[j].src[23:0], item.data};
          if (rel >= 7'd16 && rel <= 7'd19)
            rows_nxt[j].dst = {rows_r[j].dst[23:0], item.data};
          if (rel >= l4 && rel < l4 + PORT_BYTES)
            rows_nxt[j].ports4 = {rows_r[j].ports4[23:0], item.data};
          if (rel >= MIN_IPV6_LEN && rel < MIN_IPV6_L4_LEN)
            rows_nxt[j].ports6 = {rows_r[j].ports6[23:0], item.data};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
    rows_r <= rows_nxt;
  end

  assign done = done_r;
  assign link = link_r;
  assign rows = rows_r;

endmodule

// ===== rtl/phf_verdict.sv =====
// Verdict logic: link kind detection and the configured filter checks.
// Depends on phf_pkg; fed from the registers of phf_capture.
module phf_verdict (
  input  phf_pkg::cfg_t         cfg,
  input  phf_pkg::link_fields_t link,
  input  phf_pkg::l3_fields_t   rows [phf_pkg::NUM_ROWS],
  output phf_pkg::verdict_t     verdict
);
  import phf_pkg::*;

  function automatic logic port_ok(input cfg_t c, input logic [31:0] ports,
                                   input logic [7:0] proto);
    logic [15:0] sp;
    logic [15:0] dp;
    logic        ok;
    sp = ports[31:16];
    dp = ports[15:0];
    case (c.filter_mode)
      MODE_HTTP:  ok = (sp == PORT_HTTP) || (dp == PORT_HTTP);
      MODE_HTTPS: ok = (sp == PORT_HTTPS) || (dp == PORT_HTTPS);
      MODE_DNS:   ok = (sp == PORT_DNS) || (dp == PORT_DNS);
      MODE_TCP:   ok = (proto == PROTO_TCP);
      MODE_UDP:   ok = (proto == PROTO_UDP);
      default:    ok = (c.match_source_port == PORT_ANY || sp == c.match_source_port) &&
                       (c.match_dest_port == PORT_ANY || dp == c.match_dest_port);
    endcase
    return ok;
  endfunction

  logic [3:0]       ver;
  logic             is_raw, is_cooked, is_eth;
  l3_fields_t       r;
  logic [POS_W-1:0] off, cap, l4_need;
  logic [15:0]      et;
  logic [1:0]       kind;
  logic             all_mode, acc_v4, acc_v6, acc;

  assign ver = link.word0[15:12];
  assign all_mode = (cfg.filter_mode != MODE_ARP) && (cfg.filter_mode != MODE_HTTP) &&
                    (cfg.filter_mode != MODE_HTTPS) && (cfg.filter_mode != MODE_DNS) &&
                    (cfg.filter_mode != MODE_TCP) && (cfg.filter_mode != MODE_UDP);

  always_comb begin
    is_raw = (link.len >= MIN_RAW_LEN) && (ver == IP_VER4 || ver == IP_VER6);
    is_cooked = !is_raw && (link.len >= MIN_COOKED_LEN) &&
                ver != IP_VER4 && ver != IP_VER6 &&
                (link.word0 <= SLL_PKTTYPE_MAX) &&
                (link.word2 == ARPHRD_NETROM || link.word2 == ARPHRD_ETHER ||
                 link.word2 == ARPHRD_LOOPBACK);
    is_eth = !is_raw && !is_cooked && (link.len >= MIN_ETH_LEN);

    if (is_raw) begin
      kind = KIND_RAW;
      et = (ver == IP_VER4) ? ET_IPV4 : ET_IPV6;
      r = rows[ROW_RAW];
      off = L3_OFF[ROW_RAW];
    end else if (is_cooked) begin
      kind = KIND_COOKED;
      et = link.et14;
      r = rows[ROW_COOKED];
      off = L3_OFF[ROW_COOKED];
    end else if (is_eth) begin
      kind = KIND_ETH;
      et = link.et12;
      r = rows[ROW_ETH];
      off = L3_OFF[ROW_ETH];
    end else begin
      kind = KIND_TRUNC;
      et = ET_NONE;
      r = rows[ROW_RAW];
      off = L3_OFF[ROW_RAW];
    end

    cap = link.len - off;
    l4_need = {1'b0, r.ihl, 2'b00} + PORT_BYTES;

    acc_v4 = (cfg.match_protocol == PROTO_ANY || r.proto == cfg.match_protocol) &&
             (!cfg.source_address_enable || r.src == cfg.source_address) &&
             (!cfg.dest_address_enable || r.dst == cfg.dest_address);
    if (acc_v4 && (r.proto == PROTO_TCP || r.proto == PROTO_UDP) && cap >= l4_need)
      acc_v4 = port_ok(cfg, r.ports4, r.proto);

    acc_v6 = (cfg.match_protocol == PROTO_ANY || r.nh == cfg.match_protocol);
    if (acc_v6 && (r.nh == PROTO_TCP || r.nh == PROTO_UDP) && cap >= MIN_IPV6_L4_LEN)
      acc_v6 = port_ok(cfg, r.ports6, r.nh);

    if (kind == KIND_TRUNC)
      acc = 1'b0;
    else if (cfg.filter_mode == MODE_ARP)
      acc = (et == ET_ARP);
    else if (et == ET_IPV4 && cap >= MIN_IPV4_LEN)
      acc = acc_v4;
    else if (et == ET_IPV6 && cap >= MIN_IPV6_LEN)
      acc = acc_v6;
    else
      acc = all_mode;

    verdict.accept = acc;
    verdict.link_kind = kind;
    verdict.ether_type = et;
  end

endmodule
